// ===== src/fimas_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fimas_pkg
// Shared types, constants and the lowest-set-bit encoder for the interrupt
// mask and select block.
// ----------------------------------------------------------------------------
package fimas_pkg;

  // Request codes carried on the input channel
  typedef enum logic [1:0] {
    REQ_MASK   = 2'd0,
    REQ_UNMASK = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  localparam int unsigned GPIO_BASE_LINE   = 96;
  localparam int unsigned TOTAL_LINES_DEF  = 192;
  localparam int unsigned WORD_BITS        = 32;
  localparam int unsigned LINE_W           = 8;
  localparam int unsigned BIT_IDX_W        = 5;
  localparam int unsigned LOW_WORD_END     = 32;
  localparam int unsigned HIGH_WORD_END    = 64;
  // High cause bits in this span stand for the first line of a GPIO group
  localparam int unsigned GPIO_SUM_FIRST   = 4;
  localparam int unsigned GPIO_SUM_LAST    = 15;
  localparam int unsigned GPIO_GROUP_SHIFT = 3;

  typedef struct packed {
    logic                 hit;
    logic [BIT_IDX_W-1:0] idx;
  } lsb_t;

  // Lowest set bit of a word; hit is low when the word is zero
  function automatic lsb_t lowest_bit(input logic [WORD_BITS-1:0] w);
    lsb_t res;
    res.hit = 1'b0;
    res.idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        res.hit = 1'b1;
        res.idx = BIT_IDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== src/fast_interrupt_mask_and_select.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fast_interrupt_mask_and_select
// Per-line interrupt enable store with a lowest-line-wins pending selector.
// ----------------------------------------------------------------------------
// Each request passes the request register, then the result register.
// Throughput: one request per cycle; busy never rises, and each result sits on
//   the out_ ports for exactly one cycle since the receiver cannot stall.
// Rate is set by the single compute stage between the request register and
//   the result register: one mask update or one priority encode per cycle.
// Reset (rst_n low, synchronous): all lines masked, polarity cleared, no
//   request in flight and no result strobe.
// ----------------------------------------------------------------------------
module fast_interrupt_mask_and_select #(
  parameter int unsigned TOTAL_LINES = fimas_pkg::TOTAL_LINES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [fimas_pkg::LINE_W-1:0]  in_line,
  input  wire logic                          in_change_level,
  input  wire logic [31:0]                   in_cause_low,
  input  wire logic [31:0]                   in_cause_high,
  input  wire logic [31:0]                   in_cause_error,
  // result channel
  output logic                               out_valid,
  output logic [fimas_pkg::LINE_W-1:0]       out_pending_line,
  output logic                               out_found,
  output logic                               out_out_of_range
);

  // Number of 32-line GPIO group words above the base line
  localparam int unsigned GPIO_WORDS =
    (TOTAL_LINES - fimas_pkg::GPIO_BASE_LINE + fimas_pkg::WORD_BITS - 1) /
    fimas_pkg::WORD_BITS;
  localparam int unsigned LW = fimas_pkg::LINE_W;

  // --------------------------------------------------------------------------
  // Request register: capture the transfer as it is accepted
  // --------------------------------------------------------------------------
  logic                   req_vld_r;
  fimas_pkg::req_t        req_type_r;
  logic [LW-1:0]          line_r;
  logic                   chg_r;
  logic [31:0]            c_low_r;
  logic [31:0]            c_high_r;
  logic [31:0]            c_err_r;
  logic                   accept;

  // The compute stage finishes one request every cycle, so never hold off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= accept;
    end
  end

  // Payload needs no reset; it is only looked at under req_vld_r
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= fimas_pkg::req_t'(in_req_type);
      line_r     <= in_line;
      chg_r      <= in_change_level;
      c_low_r    <= in_cause_low;
      c_high_r   <= in_cause_high;
      c_err_r    <= in_cause_error;
    end
  end

  // --------------------------------------------------------------------------
  // Enable and polarity state
  // --------------------------------------------------------------------------
  logic [31:0] mask_low_r,  mask_low_nxt;
  logic [31:0] mask_high_r, mask_high_nxt;
  logic [31:0] mask_err_r,  mask_err_nxt;
  logic [31:0] gpio_mask_r [GPIO_WORDS];
  logic [31:0] gpio_mask_nxt [GPIO_WORDS];
  logic [31:0] gpio_pol_r  [GPIO_WORDS];
  logic [31:0] gpio_pol_nxt [GPIO_WORDS];

  // --------------------------------------------------------------------------
  // Mask / unmask decode
  // --------------------------------------------------------------------------
  logic          is_set_req;
  logic          enable;
  logic          line_oor;
  logic [31:0]   line_bit;
  logic [LW-1:0] gpio_off;
  logic [1:0]    gpio_grp;

  assign is_set_req = req_vld_r && (req_type_r == fimas_pkg::REQ_MASK ||
                                    req_type_r == fimas_pkg::REQ_UNMASK);
  assign enable     = (req_type_r == fimas_pkg::REQ_UNMASK);
  assign line_oor   = (line_r >= LW'(TOTAL_LINES));
  assign line_bit   = 32'(1) << line_r[fimas_pkg::BIT_IDX_W-1:0];
  assign gpio_off   = line_r - LW'(fimas_pkg::GPIO_BASE_LINE);
  assign gpio_grp   = gpio_off[6:5];

  always_comb begin
    mask_low_nxt  = mask_low_r;
    mask_high_nxt = mask_high_r;
    mask_err_nxt  = mask_err_r;
    for (int g = 0; g < GPIO_WORDS; g++) begin
      gpio_mask_nxt[g] = gpio_mask_r[g];
      gpio_pol_nxt[g]  = gpio_pol_r[g];
    end
    // Drop out-of-range lines without touching any word
    if (is_set_req && !line_oor) begin
      if (line_r < LW'(fimas_pkg::LOW_WORD_END)) begin
        mask_low_nxt = enable ? (mask_low_r | line_bit) : (mask_low_r & ~line_bit);
      end else if (line_r < LW'(fimas_pkg::HIGH_WORD_END)) begin
        mask_high_nxt = enable ? (mask_high_r | line_bit) : (mask_high_r & ~line_bit);
      end else if (line_r < LW'(fimas_pkg::GPIO_BASE_LINE)) begin
        mask_err_nxt = enable ? (mask_err_r | line_bit) : (mask_err_r & ~line_bit);
      end else begin
        for (int g = 0; g < GPIO_WORDS; g++) begin
          if (gpio_grp == 2'(g)) begin
            if (enable) begin
              gpio_mask_nxt[g] = gpio_mask_r[g] | line_bit;
              // Change-level lines flip their sense on every unmask
              if (chg_r) begin
                gpio_pol_nxt[g] = gpio_pol_r[g] ^ line_bit;
              end
            end else begin
              gpio_mask_nxt[g] = gpio_mask_r[g] & ~line_bit;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_low_r  <= '0;
      mask_high_r <= '0;
      mask_err_r  <= '0;
      for (int g = 0; g < GPIO_WORDS; g++) begin
        gpio_mask_r[g] <= '0;
        gpio_pol_r[g]  <= '0;
      end
    end else begin
      mask_low_r  <= mask_low_nxt;
      mask_high_r <= mask_high_nxt;
      mask_err_r  <= mask_err_nxt;
      for (int g = 0; g < GPIO_WORDS; g++) begin
        gpio_mask_r[g] <= gpio_mask_nxt[g];
        gpio_pol_r[g]  <= gpio_pol_nxt[g];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pending-line selection: low word, then high word (only when the raw
  // summary bit is set), then error word; lowest bit wins in each
  // --------------------------------------------------------------------------
  fimas_pkg::lsb_t lsb_low;
  fimas_pkg::lsb_t lsb_high;
  fimas_pkg::lsb_t lsb_err;
  logic [LW-1:0]   high_line;
  logic [LW-1:0]   pick;
  logic            pick_hit;

  assign lsb_low  = fimas_pkg::lowest_bit(c_low_r  & mask_low_r);
  assign lsb_high = fimas_pkg::lowest_bit(c_high_r & mask_high_r);
  assign lsb_err  = fimas_pkg::lowest_bit(c_err_r  & mask_err_r);

  // GPIO summary bits name the first line of their group of eight
  always_comb begin
    if (lsb_high.idx >= fimas_pkg::BIT_IDX_W'(fimas_pkg::GPIO_SUM_FIRST) &&
        lsb_high.idx <= fimas_pkg::BIT_IDX_W'(fimas_pkg::GPIO_SUM_LAST)) begin
      high_line = LW'(fimas_pkg::GPIO_BASE_LINE) +
                  (LW'(lsb_high.idx - fimas_pkg::BIT_IDX_W'(fimas_pkg::GPIO_SUM_FIRST))
                   << fimas_pkg::GPIO_GROUP_SHIFT);
    end else begin
      high_line = LW'(lsb_high.idx) + LW'(fimas_pkg::LOW_WORD_END);
    end
  end

  always_comb begin
    pick     = '0;
    pick_hit = 1'b0;
    if (lsb_low.hit) begin
      pick     = LW'(lsb_low.idx);
      pick_hit = 1'b1;
    end else if (c_low_r[0] && lsb_high.hit) begin
      pick     = high_line;
      pick_hit = 1'b1;
    end else if (lsb_err.hit) begin
      pick     = LW'(lsb_err.idx);
      pick_hit = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: one strobe per request
  // --------------------------------------------------------------------------
  logic          out_valid_r;
  logic [LW-1:0] out_line_r, out_line_nxt;
  logic          out_found_r, out_found_nxt;
  logic          out_oor_r, out_oor_nxt;

  always_comb begin
    out_line_nxt  = '0;
    out_found_nxt = 1'b0;
    out_oor_nxt   = 1'b0;
    case (req_type_r)
      fimas_pkg::REQ_MASK,
      fimas_pkg::REQ_UNMASK: begin
        out_oor_nxt = line_oor;
      end
      fimas_pkg::REQ_QUERY: begin
        out_line_nxt  = pick;
        out_found_nxt = pick_hit;
      end
      default: begin
        out_oor_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      out_line_r  <= out_line_nxt;
      out_found_r <= out_found_nxt;
      out_oor_r   <= out_oor_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pending_line = out_line_r;
  assign out_found        = out_found_r;
  assign out_out_of_range = out_oor_r;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interrupt mask and select block. A driver takes
// requests from a queue and presents them on the start/busy handshake. A
// monitor predicts each transfer from its own copy of the enable words and
// compares every result strobe with the oldest prediction. Stimulus is a short
// directed set, then three randomised phases of request gaps.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    fimas_pkg::req_t req;
    logic [7:0]      line;
    logic            chg;
    logic [31:0]     c_low;
    logic [31:0]     c_high;
    logic [31:0]     c_err;
    int unsigned     gap_pct;   // chance in a hundred of an idle cycle before launch
    bit              wait_idle; // hold launch until every result is back
  } irq_request_t;

  typedef struct packed {
    logic [7:0] line;
    logic       found;
    logic       oor;
  } irq_outcome_t;

  localparam int unsigned PHASE_ITEMS = 545;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_req_type = fimas_pkg::REQ_NONE;
  logic [7:0]  in_line = '0;
  logic        in_change_level = 1'b0;
  logic [31:0] in_cause_low = '0;
  logic [31:0] in_cause_high = '0;
  logic [31:0] in_cause_error = '0;
  logic        busy;
  logic        out_valid;
  logic [7:0]  out_pending_line;
  logic        out_found;
  logic        out_out_of_range;

  irq_request_t pending_reqs[$];
  irq_outcome_t expected_q[$];
  int           errors = 0;
  int           in_flight = 0;

  // Predictor copy of the enable words. Polarity bits never reach the result
  // ports, so they are not tracked.
  logic [31:0] en_low = '0;
  logic [31:0] en_high = '0;
  logic [31:0] en_err = '0;
  logic [31:0] en_gpio[3] = '{default: '0};

  fast_interrupt_mask_and_select u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_line          (in_line),
    .in_change_level  (in_change_level),
    .in_cause_low     (in_cause_low),
    .in_cause_high    (in_cause_high),
    .in_cause_error   (in_cause_error),
    .out_valid        (out_valid),
    .out_pending_line (out_pending_line),
    .out_found        (out_found),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Index of the lowest set bit; the caller makes sure the word is not zero
  function automatic int unsigned first_pending(logic [31:0] w);
    int unsigned i;
    i = 0;
    while (i < fimas_pkg::WORD_BITS - 1 && !w[i]) i++;
    return i;
  endfunction

  function automatic logic [31:0] set_or_clear(logic [31:0] w, int unsigned pos, bit en);
    logic [31:0] sel;
    sel = 32'd1 << pos;
    return en ? (w | sel) : (w & ~sel);
  endfunction

  // Work out the result of one transfer and advance the enable words
  function automatic irq_outcome_t resolve_request(fimas_pkg::req_t req, logic [7:0] line,
                                                   logic [31:0] c_low,
                                                   logic [31:0] c_high,
                                                   logic [31:0] c_err);
    irq_outcome_t res;
    int unsigned  b;
    int unsigned  pos;
    int unsigned  grp;
    bit           en;
    res = '0;
    pos = line % fimas_pkg::WORD_BITS;
    en  = (req == fimas_pkg::REQ_UNMASK);
    case (req)
      fimas_pkg::REQ_MASK, fimas_pkg::REQ_UNMASK: begin
        if (line >= fimas_pkg::TOTAL_LINES_DEF) begin
          res.oor = 1'b1;
        end else if (line < fimas_pkg::LOW_WORD_END) begin
          en_low = set_or_clear(en_low, pos, en);
        end else if (line < fimas_pkg::HIGH_WORD_END) begin
          en_high = set_or_clear(en_high, pos, en);
        end else if (line < fimas_pkg::GPIO_BASE_LINE) begin
          en_err = set_or_clear(en_err, pos, en);
        end else begin
          grp = (line - fimas_pkg::GPIO_BASE_LINE) / fimas_pkg::WORD_BITS;
          en_gpio[grp] = set_or_clear(en_gpio[grp], pos, en);
        end
      end
      fimas_pkg::REQ_QUERY: begin
        if ((c_low & en_low) != 0) begin
          res.found = 1'b1;
          res.line  = 8'(first_pending(c_low & en_low));
        end else if (c_low[0] && (c_high & en_high) != 0) begin
          // High summary bits stand for the first line of a GPIO group
          b = first_pending(c_high & en_high);
          res.found = 1'b1;
          if (b >= fimas_pkg::GPIO_SUM_FIRST && b <= fimas_pkg::GPIO_SUM_LAST)
            res.line = 8'(fimas_pkg::GPIO_BASE_LINE +
                          ((b - fimas_pkg::GPIO_SUM_FIRST) << fimas_pkg::GPIO_GROUP_SHIFT));
          else
            res.line = 8'(fimas_pkg::LOW_WORD_END + b);
        end else if ((c_err & en_err) != 0) begin
          res.found = 1'b1;
          res.line  = 8'(first_pending(c_err & en_err));
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Cause word shapes: empty, a single bit, all ones or fully random, so that
  // the search falls through to the high and error words often enough
  function automatic logic [31:0] random_cause();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return 32'd1 << $urandom_range(0, 31);
      5:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic irq_request_t random_request(int unsigned gap);
    irq_request_t r;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      r.req = fimas_pkg::REQ_MASK;
    else if (pick < 60) r.req = fimas_pkg::REQ_UNMASK;
    else if (pick < 95) r.req = fimas_pkg::REQ_QUERY;
    else                r.req = fimas_pkg::REQ_NONE;
    r.line      = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(192, 255))
                                              : 8'($urandom_range(0, 191));
    r.chg       = 1'($urandom_range(0, 1));
    r.c_low     = random_cause();
    if ($urandom_range(0, 1)) r.c_low[0] = 1'b1;
    r.c_high    = random_cause();
    r.c_err     = random_cause();
    r.gap_pct   = gap;
    r.wait_idle = 1'b0;
    return r;
  endfunction

  task automatic directed(fimas_pkg::req_t req, logic [7:0] line, logic chg,
                          logic [31:0] c_low, logic [31:0] c_high, logic [31:0] c_err);
    irq_request_t r;
    r = '{req, line, chg, c_low, c_high, c_err, 31, 1'b0};
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: launch the next queued request when the slot is free, hold it
  // while busy, and drop start on idle cycles
  always @(posedge clk) begin
    irq_request_t nxt;
    bit           go;
    if (!rst_n) begin
      start     <= 1'b0;
      in_flight = 0;
    end else begin
      if (start && !busy) in_flight++;
      if (out_valid) in_flight--;
      if (!(start && busy)) begin
        go = 1'b0;
        if (pending_reqs.size() != 0) begin
          nxt = pending_reqs[0];
          if (!(nxt.wait_idle && in_flight > 0))
            go = ($urandom_range(0, 99) >= nxt.gap_pct);
        end
        if (go) begin
          void'(pending_reqs.pop_front());
          start           <= 1'b1;
          in_req_type     <= nxt.req;
          in_line         <= nxt.line;
          in_change_level <= nxt.chg;
          in_cause_low    <= nxt.c_low;
          in_cause_high   <= nxt.c_high;
          in_cause_error  <= nxt.c_err;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check the strobed result first, then predict the transfer taken
  // at this edge; the block's latency keeps the two apart
  always @(posedge clk) begin
    irq_outcome_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: result with nothing expected, actual line %0d found %0b oor %0b",
                     $time, out_pending_line, out_found, out_out_of_range);
        end else begin
          want = expected_q.pop_front();
          check_field("pending_line", want.line, out_pending_line);
          check_field("found", 8'(want.found), 8'(out_found));
          check_field("out_of_range", 8'(want.oor), 8'(out_out_of_range));
        end
      end
      if (start && !busy)
        expected_q.push_back(resolve_request(fimas_pkg::req_t'(in_req_type), in_line,
                                             in_cause_low, in_cause_high, in_cause_error));
    end
  end

  initial begin
    irq_request_t r;
    int unsigned  gaps[3];
    gaps = '{31, 63, 0};

    // Directed: empty masks, word boundaries, summary bit extremes, lines out
    // of range and the unused request code
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b1, '1, '1, '1);
    directed(fimas_pkg::REQ_MASK,   8'd0,   1'b0, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd31,  1'b0, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd32,  1'b1, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd36,  1'b0, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd47,  1'b0, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd63,  1'b0, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd64,  1'b0, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd95,  1'b0, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd96,  1'b1, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd191, 1'b1, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd192, 1'b0, '1, '1, '1);
    directed(fimas_pkg::REQ_MASK,   8'd255, 1'b0, '0, '0, '0);
    directed(fimas_pkg::REQ_UNMASK, 8'd255, 1'b1, '0, '0, '0);
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b0, '1, '1, '1);
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b0, 32'h1, '1, '1);
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b0, 32'h1, 32'hFFFF_FFF0, '0);
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b1, 32'h1, 32'h0000_8000, '0);
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b0, 32'h1, 32'h8000_0000, '0);
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b0, '0, '1, '1);
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b0, 32'h1, 32'h2, 32'h8000_0000);
    directed(fimas_pkg::REQ_MASK,   8'd31,  1'b1, '0, '0, '0);
    directed(fimas_pkg::REQ_QUERY,  8'd0,   1'b0, 32'h8000_0000, '1, '0);
    directed(fimas_pkg::REQ_NONE,   8'd5,   1'b1, '1, '1, '1);
    directed(fimas_pkg::REQ_MASK,   8'd191, 1'b0, '1, '1, '1);

    // Random phases; each opens only once the block has drained
    foreach (gaps[p]) begin
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = random_request(gaps[p]);
        r.wait_idle = (i == 0);
        pending_reqs.push_back(r);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last transfer and its result, then allow for the latency
    // so that any stray strobe is still caught
    @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_q.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);

    if (errors == 0) begin
      $display("[fast_interrupt_mask_and_select] OK");
    end else begin
      $display("[fast_interrupt_mask_and_select] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #1000000;
    $display("[fast_interrupt_mask_and_select] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
